// ===== rtl/qrr_pkg.sv =====
package qrr_pkg;

   localparam int ROOT_W = 34;
   localparam int OUT_DATA_W = ((2 * ROOT_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ST_TWO_ROOTS  = 2'd0,
      ST_REPEATED   = 2'd1,
      ST_NO_REAL    = 2'd2,
      ST_A_ZERO     = 2'd3
   } status_type;

endpackage

// ===== rtl/qrr_disc.sv =====
module qrr_disc #(
   parameter int W = 16,
   localparam int DW = 2 * W + 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic signed [W-1:0]    in_a,
   input  logic signed [W-1:0]    in_b,
   input  logic signed [W-1:0]    in_c,
   output logic                   out_valid,
   output logic [DW-2:0]          out_delta,
   output logic signed [W-1:0]    out_a,
   output logic signed [W-1:0]    out_b,
   output qrr_pkg::status_type    out_status
);

   logic                  v1_ff;
   logic signed [W-1:0]   a1_ff, b1_ff;
   logic signed [2*W-1:0] bb_ff, ac_ff;

   logic                  v2_ff;
   logic [DW-2:0]         delta_ff, delta_in;
   logic signed [W-1:0]   a2_ff, b2_ff;
   qrr_pkg::status_type   status_ff, status_in;
   logic signed [DW-1:0]  delta;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a1_ff <= in_a;
         b1_ff <= in_b;
         bb_ff <= in_b * in_b;
         ac_ff <= in_a * in_c;
      end
   end

   always_comb begin
      delta = DW'(bb_ff) - (DW'(ac_ff) <<< 2);
      priority if (a1_ff == '0) begin
         status_in = qrr_pkg::ST_A_ZERO;
      end else if (delta < 0) begin
         status_in = qrr_pkg::ST_NO_REAL;
      end else if (delta == '0) begin
         status_in = qrr_pkg::ST_REPEATED;
      end else begin
         status_in = qrr_pkg::ST_TWO_ROOTS;
      end
      delta_in = (delta < 0) ? '0 : delta[DW-2:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         delta_ff  <= delta_in;
         a2_ff     <= a1_ff;
         b2_ff     <= b1_ff;
         status_ff <= status_in;
      end
   end

   assign out_valid  = v2_ff;
   assign out_delta  = delta_ff;
   assign out_a      = a2_ff;
   assign out_b      = b2_ff;
   assign out_status = status_ff;

endmodule

// ===== rtl/qrr_sqrt.sv =====
module qrr_sqrt #(
   parameter int IN_W = 33,
   parameter int FRAC_BITS = 16,
   parameter int TAG_W = 34,
   localparam int SW = (IN_W + 2 * FRAC_BITS + 1) / 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [IN_W-1:0]   in_value,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   output logic [SW-1:0]     out_root,
   output logic [TAG_W-1:0]  out_tag
);

   localparam int RADW = 2 * SW;
   localparam int RMW = SW + 2;

   logic [SW-1:0]    valid_ff;
   logic [RADW-1:0]  rad_ff  [SW];
   logic [RMW-1:0]   rem_ff  [SW];
   logic [SW-1:0]    root_ff [SW];
   logic [TAG_W-1:0] tag_ff  [SW];

   logic             stg_valid [SW+1];
   logic [RADW-1:0]  stg_rad   [SW+1];
   logic [RMW-1:0]   stg_rem   [SW+1];
   logic [SW-1:0]    stg_root  [SW+1];
   logic [TAG_W-1:0] stg_tag   [SW+1];

   assign stg_valid[0] = in_valid;
   assign stg_rad[0]   = RADW'(in_value) << (2 * FRAC_BITS);
   assign stg_rem[0]   = '0;
   assign stg_root[0]  = '0;
   assign stg_tag[0]   = in_tag;

   for (genvar k = 0; k < SW; k++) begin : g_stage
      logic [RMW-1:0] rem_sh, trial, rem_in;
      logic [SW-1:0]  root_in;
      logic           ge;

      assign stg_valid[k+1] = valid_ff[k];
      assign stg_rad[k+1]   = rad_ff[k];
      assign stg_rem[k+1]   = rem_ff[k];
      assign stg_root[k+1]  = root_ff[k];
      assign stg_tag[k+1]   = tag_ff[k];

      always_comb begin
         rem_sh  = {stg_rem[k][RMW-3:0], stg_rad[k][RADW-1 -: 2]};
         trial   = {stg_root[k], 2'b01};
         ge      = (rem_sh >= trial);
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {stg_root[k][SW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= stg_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[k]  <= stg_rad[k] << 2;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            tag_ff[k]  <= stg_tag[k];
         end
      end
   end

   assign out_valid = stg_valid[SW];
   assign out_root  = stg_root[SW];
   assign out_tag   = stg_tag[SW];

endmodule

// ===== rtl/qrr_div2.sv =====
module qrr_div2 #(
   parameter int NW = 35,
   parameter int DENW = 17,
   parameter int TAG_W = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic signed [NW-1:0]  in_num1,
   input  logic signed [NW-1:0]  in_num2,
   input  logic signed [DENW-1:0] in_den,
   input  logic [TAG_W-1:0]      in_tag,
   output logic                  out_valid,
   output logic signed [NW-1:0]  out_quo1,
   output logic signed [NW-1:0]  out_quo2,
   output logic [TAG_W-1:0]      out_tag
);

   logic              v0_ff;
   logic [NW-1:0]     n1_0_ff, n2_0_ff;
   logic [DENW-1:0]   dm_0_ff;
   logic              neg1_0_ff, neg2_0_ff;
   logic [TAG_W-1:0]  tag_0_ff;

   logic [NW-1:0]     valid_ff;
   logic [NW-1:0]     n1_ff   [NW];
   logic [NW-1:0]     n2_ff   [NW];
   logic [DENW-1:0]   r1_ff   [NW];
   logic [DENW-1:0]   r2_ff   [NW];
   logic [DENW-1:0]   dm_ff   [NW];
   logic              neg1_ff [NW];
   logic              neg2_ff [NW];
   logic [TAG_W-1:0]  tag_ff  [NW];

   logic              stg_valid [NW+1];
   logic [NW-1:0]     stg_n1    [NW+1];
   logic [NW-1:0]     stg_n2    [NW+1];
   logic [DENW-1:0]   stg_r1    [NW+1];
   logic [DENW-1:0]   stg_r2    [NW+1];
   logic [DENW-1:0]   stg_dm    [NW+1];
   logic              stg_neg1  [NW+1];
   logic              stg_neg2  [NW+1];
   logic [TAG_W-1:0]  stg_tag   [NW+1];

   logic              vq_ff;
   logic signed [NW-1:0] q1_ff, q2_ff;
   logic [TAG_W-1:0]  tagq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         vq_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= in_valid;
         vq_ff <= stg_valid[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n1_0_ff   <= in_num1[NW-1] ? NW'(-in_num1) : NW'(in_num1);
         n2_0_ff   <= in_num2[NW-1] ? NW'(-in_num2) : NW'(in_num2);
         dm_0_ff   <= in_den[DENW-1] ? DENW'(-in_den) : DENW'(in_den);
         neg1_0_ff <= in_num1[NW-1] ^ in_den[DENW-1];
         neg2_0_ff <= in_num2[NW-1] ^ in_den[DENW-1];
         tag_0_ff  <= in_tag;
      end
   end

   assign stg_valid[0] = v0_ff;
   assign stg_n1[0]    = n1_0_ff;
   assign stg_n2[0]    = n2_0_ff;
   assign stg_r1[0]    = '0;
   assign stg_r2[0]    = '0;
   assign stg_dm[0]    = dm_0_ff;
   assign stg_neg1[0]  = neg1_0_ff;
   assign stg_neg2[0]  = neg2_0_ff;
   assign stg_tag[0]   = tag_0_ff;

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic [DENW:0]   sh1, sh2, dext;
      logic            ge1, ge2;
      logic [DENW-1:0] r1_in, r2_in;

      assign stg_valid[k+1] = valid_ff[k];
      assign stg_n1[k+1]    = n1_ff[k];
      assign stg_n2[k+1]    = n2_ff[k];
      assign stg_r1[k+1]    = r1_ff[k];
      assign stg_r2[k+1]    = r2_ff[k];
      assign stg_dm[k+1]    = dm_ff[k];
      assign stg_neg1[k+1]  = neg1_ff[k];
      assign stg_neg2[k+1]  = neg2_ff[k];
      assign stg_tag[k+1]   = tag_ff[k];

      always_comb begin
         dext  = {1'b0, stg_dm[k]};
         sh1   = {stg_r1[k], stg_n1[k][NW-1]};
         sh2   = {stg_r2[k], stg_n2[k][NW-1]};
         ge1   = (sh1 >= dext);
         ge2   = (sh2 >= dext);
         r1_in = ge1 ? DENW'(sh1 - dext) : DENW'(sh1);
         r2_in = ge2 ? DENW'(sh2 - dext) : DENW'(sh2);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= stg_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            n1_ff[k]   <= {stg_n1[k][NW-2:0], ge1};
            n2_ff[k]   <= {stg_n2[k][NW-2:0], ge2};
            r1_ff[k]   <= r1_in;
            r2_ff[k]   <= r2_in;
            dm_ff[k]   <= stg_dm[k];
            neg1_ff[k] <= stg_neg1[k];
            neg2_ff[k] <= stg_neg2[k];
            tag_ff[k]  <= stg_tag[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q1_ff   <= stg_neg1[NW] ? -signed'(stg_n1[NW]) : signed'(stg_n1[NW]);
         q2_ff   <= stg_neg2[NW] ? -signed'(stg_n2[NW]) : signed'(stg_n2[NW]);
         tagq_ff <= stg_tag[NW];
      end
   end

   assign out_valid = vq_ff;
   assign out_quo1  = q1_ff;
   assign out_quo2  = q2_ff;
   assign out_tag   = tagq_ff;

endmodule

// ===== rtl/quadratic_real_roots.sv =====
// Channel  Direction  tdata                                     tuser
// req      in         coef_a, coef_b, coef_c (COEF_WIDTH each)  -
// rsp      out        root_large, root_small (34 bits each)     status
//
// One coefficient set per cycle while req_tready is high. The pipeline includes
// SW = COEF_WIDTH + FRAC_BITS + 1 square-root stages and NW = COEF_WIDTH + FRAC_BITS + 3
// divider stages.
// Synchronous reset clears all valid bits; data registers are not reset.
// When a result is held on rsp, the whole pipeline freezes and req_tready falls.
module quadratic_real_roots #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS = 16,
   localparam int IN_DATA_W = ((3 * COEF_WIDTH + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [IN_DATA_W-1:0]               req_tdata,  // coef_a, coef_b, coef_c
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [qrr_pkg::OUT_DATA_W-1:0]     rsp_tdata,  // root_large, root_small
   output logic [1:0]                         rsp_tuser   // status
);

   localparam int W = COEF_WIDTH;
   localparam int DW = 2 * W + 2;
   localparam int SW = (DW - 1 + 2 * FRAC_BITS + 1) / 2;
   localparam int NW = W + FRAC_BITS + 3;
   localparam int DENW = W + 1;
   localparam int RW = qrr_pkg::ROOT_W;
   localparam int EW = ((NW > RW) ? NW : RW) + 1;
   localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (RW - 1)) - 64'sd1);
   localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);
   localparam int TAG_W = 2 + 2 * W;

   logic advance;

   logic                 d_valid;
   logic [DW-2:0]        d_delta;
   logic signed [W-1:0]  d_a, d_b;
   qrr_pkg::status_type  d_status;

   logic                 s_valid;
   logic [SW-1:0]        s_root;
   logic [TAG_W-1:0]     s_tag;

   logic                 n_valid_ff;
   logic signed [NW-1:0] n1_ff, n2_ff;
   logic signed [DENW-1:0] den_ff;
   logic [1:0]           n_status_ff;
   logic signed [W-1:0]  s_a, s_b;
   logic signed [NW-1:0] nb;

   logic                 q_valid;
   logic signed [NW-1:0] q1, q2;
   logic [1:0]           q_status;

   logic                 t_valid_ff;
   logic signed [RW-1:0] t1_ff, t2_ff, t1_in, t2_in;
   logic [1:0]           t_status_ff;
   logic signed [EW-1:0] q1e, q2e;

   logic                 rsp_valid_ff;
   logic [RW-1:0]        large_ff, small_ff, large_in, small_in;
   qrr_pkg::status_type  rsp_status_ff, t_status;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   qrr_disc #(.W(W)) u_disc (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .in_a       (req_tdata[W-1:0]),
      .in_b       (req_tdata[2*W-1:W]),
      .in_c       (req_tdata[3*W-1:2*W]),
      .out_valid  (d_valid),
      .out_delta  (d_delta),
      .out_a      (d_a),
      .out_b      (d_b),
      .out_status (d_status)
   );

   qrr_sqrt #(.IN_W(DW - 1), .FRAC_BITS(FRAC_BITS), .TAG_W(TAG_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d_valid),
      .in_value  (d_delta),
      .in_tag    ({d_status, d_b, d_a}),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_tag   (s_tag)
   );

   assign s_a = s_tag[W-1:0];
   assign s_b = s_tag[2*W-1:W];
   assign nb  = -(NW'(s_b) <<< FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff   <= 1'b0;
         t_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         n_valid_ff   <= s_valid;
         t_valid_ff   <= q_valid;
         rsp_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n1_ff       <= nb + signed'({2'b00, s_root});
         n2_ff       <= nb - signed'({2'b00, s_root});
         den_ff      <= {s_a, 1'b0};
         n_status_ff <= s_tag[TAG_W-1 -: 2];
      end
   end

   qrr_div2 #(.NW(NW), .DENW(DENW), .TAG_W(2)) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (n_valid_ff),
      .in_num1   (n1_ff),
      .in_num2   (n2_ff),
      .in_den    (den_ff),
      .in_tag    (n_status_ff),
      .out_valid (q_valid),
      .out_quo1  (q1),
      .out_quo2  (q2),
      .out_tag   (q_status)
   );

   always_comb begin
      q1e = EW'(q1);
      q2e = EW'(q2);
      priority if (q1e > SAT_HI) begin
         t1_in = SAT_HI[RW-1:0];
      end else if (q1e < SAT_LO) begin
         t1_in = SAT_LO[RW-1:0];
      end else begin
         t1_in = q1e[RW-1:0];
      end
      priority if (q2e > SAT_HI) begin
         t2_in = SAT_HI[RW-1:0];
      end else if (q2e < SAT_LO) begin
         t2_in = SAT_LO[RW-1:0];
      end else begin
         t2_in = q2e[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t1_ff       <= t1_in;
         t2_ff       <= t2_in;
         t_status_ff <= q_status;
      end
   end

   always_comb begin
      t_status = qrr_pkg::status_type'(t_status_ff);
      if (t_status == qrr_pkg::ST_NO_REAL || t_status == qrr_pkg::ST_A_ZERO) begin
         large_in = '0;
         small_in = '0;
      end else if (t1_ff >= t2_ff) begin
         large_in = t1_ff;
         small_in = t2_ff;
      end else begin
         large_in = t2_ff;
         small_in = t1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         large_ff      <= large_in;
         small_ff      <= small_in;
         rsp_status_ff <= t_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = qrr_pkg::OUT_DATA_W'({small_ff, large_ff});
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== tb/sv/quadratic_real_roots_checker.sv =====
module quadratic_real_roots_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [47:0]                    req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [qrr_pkg::OUT_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]                     rsp_tuser,
   output int                             fail_count,
   output int                             pending
);

   typedef struct packed {
      qrr_pkg::status_type        status;
      logic [qrr_pkg::ROOT_W-1:0] root_large;
      logic [qrr_pkg::ROOT_W-1:0] root_small;
   } roots_type;

   roots_type roots_due[$];

   function automatic logic [63:0] scaled_sqrt(input logic [63:0] d);
      logic [63:0] root;
      logic [63:0] rem;
      logic [63:0] trial;
      logic [63:0] pair;
      root = 0;
      rem = 0;
      for (int i = 47; i >= 0; i--) begin
         pair = (i >= 16) ? ((d >> (2 * (i - 16))) & 64'd3) : 64'd0;
         rem = (rem << 2) | pair;
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic logic [qrr_pkg::ROOT_W-1:0] clamp_root(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (qrr_pkg::ROOT_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[qrr_pkg::ROOT_W-1:0];
   endfunction

   function automatic roots_type solve_roots(input logic [47:0] coefs);
      roots_type r;
      longint a;
      longint b;
      longint c;
      longint delta;
      longint sv;
      longint nb;
      longint den;
      longint r1;
      longint r2;
      a = longint'($signed(coefs[15:0]));
      b = longint'($signed(coefs[31:16]));
      c = longint'($signed(coefs[47:32]));
      r = '0;
      if (a == 0) begin
         r.status = qrr_pkg::ST_A_ZERO;
         return r;
      end
      delta = b * b - 4 * a * c;
      if (delta < 0) begin
         r.status = qrr_pkg::ST_NO_REAL;
         return r;
      end
      r.status = (delta == 0) ? qrr_pkg::ST_REPEATED : qrr_pkg::ST_TWO_ROOTS;
      sv = longint'(scaled_sqrt(delta));
      nb = -b * 65536;
      den = 2 * a;
      r1 = (nb + sv) / den;
      r2 = (nb - sv) / den;
      r.root_large = clamp_root(r1 >= r2 ? r1 : r2);
      r.root_small = clamp_root(r1 >= r2 ? r2 : r1);
      return r;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      roots_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) roots_due.push_back(solve_roots(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (roots_due.size() == 0) begin
               report("unexpected transfer", rsp_tuser, 0);
            end else begin
               want = roots_due.pop_front();
               if (rsp_tuser != want.status) report("status", rsp_tuser, want.status);
               if (rsp_tdata[qrr_pkg::ROOT_W-1:0] != want.root_large)
                  report("root_large", rsp_tdata[qrr_pkg::ROOT_W-1:0], want.root_large);
               if (rsp_tdata[2*qrr_pkg::ROOT_W-1:qrr_pkg::ROOT_W] != want.root_small)
                  report("root_small", rsp_tdata[2*qrr_pkg::ROOT_W-1:qrr_pkg::ROOT_W],
                         want.root_small);
            end
         end
         pending = roots_due.size();
      end
   end

endmodule

// ===== tb/sv/quadratic_real_roots_test.sv =====
module quadratic_real_roots_test;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [47:0]                    req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [qrr_pkg::OUT_DATA_W-1:0] rsp_tdata;
   logic [1:0]                     rsp_tuser;
   int                             fail_count;
   int                             pending;
   bit                             steady;

   quadratic_real_roots dut (.*);

   quadratic_real_roots_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= steady || ($urandom_range(99) >= 31);
   end

   task automatic send_coefs(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
      while (!steady && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {c, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_coef();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(16)) - 8);
         3: return 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int k;
      int ai;
      int bi;
      int ci;
      logic [15:0] a;
      logic [15:0] b;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      rsp_tready = 0;
      steady = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;
      send_coefs(16'd0, 16'd5, 16'd3);
      send_coefs(16'd1, 16'hfffd, 16'd2);
      send_coefs(16'd1, 16'd2, 16'd1);
      send_coefs(16'd1, 16'd0, 16'd1);
      send_coefs(16'h8000, 16'h8000, 16'h8000);
      send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
      send_coefs(16'h8000, 16'h7fff, 16'h7fff);
      send_coefs(16'h7fff, 16'h8000, 16'h8000);
      send_coefs(16'd1, 16'h8000, 16'h8000);
      send_coefs(16'hffff, 16'h7fff, 16'h7fff);
      send_coefs(16'd1, 16'h8000, 16'd0);
      send_coefs(16'hffff, 16'd0, 16'd0);
      send_coefs(16'd2, 16'd3, 16'hfffb);
      send_coefs(16'hfffe, 16'd4, 16'hfffe);
      send_coefs(16'd3, 16'd0, 16'hfff4);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      for (k = 0; k < 2000; k++) begin
         steady = (k >= 800 && k < 1100);
         if (k == 1000) begin
            req_tvalid <= 1'b0;
            while (pending != 0) @(negedge clock);
         end
         a = pick_coef();
         if ($urandom_range(3) == 0) begin
            b = 16'($signed($urandom_range(200)) - 100);
            ai = int'($signed(a));
            bi = int'($signed(b));
            ci = (bi * bi) / ((ai == 0) ? 1 : 4 * ai);
            send_coefs(a, b, 16'(ci));
         end else begin
            send_coefs(a, pick_coef(), pick_coef());
         end
      end
      steady = 0;
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/qrr_pkg.sv
rtl/qrr_disc.sv
rtl/qrr_sqrt.sv
rtl/qrr_div2.sv
rtl/quadratic_real_roots.sv
tb/sv/quadratic_real_roots_checker.sv
tb/sv/quadratic_real_roots_test.sv
